>>> hw/rtl/jcgp_pkg.sv
package jcgp_pkg;

  localparam int GROUP_WIDTH  = 8;
  localparam int MAX_GROUPS   = 8;
  localparam int MASK_W       = 64;
  localparam int RAND_W       = 8;
  localparam int GRP_W        = 3;
  localparam int BIT_W        = 3;
  localparam int CNT_W        = 4;
  localparam int CHAN_W       = GRP_W + BIT_W;
  localparam int NUM_GROUPS_DEFAULT = 8;

  localparam logic [GROUP_WIDTH-1:0] GROUP_MASK = 8'hFF;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_NONE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [RAND_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [BIT_W-1:0] rem;
  } mod_resp_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [GROUP_WIDTH-1:0] bits);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < GROUP_WIDTH; i++) begin
      n = n + CNT_W'(bits[i]);
    end
    return n;
  endfunction

  function automatic logic [BIT_W-1:0] nth_set(input logic [GROUP_WIDTH-1:0] bits,
                                               input logic [BIT_W-1:0] sel);
    logic [BIT_W-1:0] pos;
    logic [CNT_W-1:0] seen;
    logic             found;
    pos   = '0;
    seen  = '0;
    found = 1'b0;
    for (int i = 0; i < GROUP_WIDTH; i++) begin
      if (bits[i] && !found) begin
        if (seen == CNT_W'(sel)) begin
          pos   = BIT_W'(i);
          found = 1'b1;
        end
        seen = seen + 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

>>> hw/rtl/jcgp_mod_unit.sv
module jcgp_mod_unit (
  input  logic                clk,
  input  logic                rst,
  input  jcgp_pkg::mod_req_t  req,
  output jcgp_pkg::mod_resp_t resp
);

  logic                         busy;
  logic [jcgp_pkg::BIT_W-1:0]   idx;
  logic [jcgp_pkg::RAND_W-1:0]  dvd;
  logic [jcgp_pkg::CNT_W-1:0]   dvs;
  logic [jcgp_pkg::BIT_W-1:0]   rem;
  logic                         done;
  logic [jcgp_pkg::CNT_W-1:0]   trial;
  logic [jcgp_pkg::BIT_W-1:0]   rem_next;

  // one quotient bit per cycle, msb first
  always_comb begin
    trial = {rem, dvd[jcgp_pkg::RAND_W-1]};
    if (trial >= dvs) begin
      rem_next = jcgp_pkg::BIT_W'(trial - dvs);
    end else begin
      rem_next = jcgp_pkg::BIT_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        idx  <= jcgp_pkg::BIT_W'(jcgp_pkg::RAND_W - 1);
      end else if (busy) begin
        idx <= idx - 1'b1;
        if (idx == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[jcgp_pkg::RAND_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign resp.done = done;
  assign resp.rem  = rem;

endmodule

>>> hw/rtl/join_channel_group_picker.sv
// Join channel picker: each request carries a 64-bit channel mask, seen as
// NUM_GROUPS groups of eight channels, and an 8-bit random value. Starting at
// the stored group pointer the block checks one group per cycle, round-robin,
// for the first one with a free channel, then reduces the random value modulo
// that group's free count in a shared shift-subtract unit, one bit per cycle,
// and returns the (remainder)-th free channel of the group with status ok and
// the pointer moved past the group. An empty mask gives channel 0, status none
// and the pointer unchanged. One request is in flight at a time: after accept the
// group scan runs, then the eight-step modulo loop if a group has a free channel,
// and the result is held valid until taken. req_ready returns the cycle after the
// result is taken.
module join_channel_group_picker #(
  parameter int NUM_GROUPS = jcgp_pkg::NUM_GROUPS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [jcgp_pkg::MASK_W-1:0]  channel_mask,
  input  logic [jcgp_pkg::RAND_W-1:0]  random_value,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [jcgp_pkg::CHAN_W-1:0]  channel_index,
  output logic                         status,
  output logic [jcgp_pkg::GRP_W-1:0]   next_group
);

  localparam logic [jcgp_pkg::GRP_W-1:0] LAST_GROUP = jcgp_pkg::GRP_W'(NUM_GROUPS - 1);

  jcgp_pkg::state_t state, state_next;

  logic [jcgp_pkg::GRP_W-1:0]        group_pointer;
  logic [jcgp_pkg::MASK_W-1:0]       mask;
  logic [jcgp_pkg::RAND_W-1:0]       rnd;
  logic [jcgp_pkg::GRP_W-1:0]        grp;
  logic [jcgp_pkg::GRP_W-1:0]        steps;
  logic [jcgp_pkg::GROUP_WIDTH-1:0]  bits;

  logic [jcgp_pkg::GRP_W-1:0]        start_group;
  logic [jcgp_pkg::GRP_W-1:0]        grp_after;
  logic [jcgp_pkg::GROUP_WIDTH-1:0]  grp_bits;
  logic                              req_fire;
  logic                              res_fire;
  logic                              found;
  logic                              exhausted;

  jcgp_pkg::mod_req_t  mod_req;
  jcgp_pkg::mod_resp_t mod_resp;

  assign start_group = (group_pointer > LAST_GROUP) ? '0 : group_pointer;
  assign grp_after   = (grp >= LAST_GROUP) ? '0 : grp + 1'b1;
  assign grp_bits    = mask[{grp, {jcgp_pkg::BIT_W{1'b0}}} +: jcgp_pkg::GROUP_WIDTH]
                       & jcgp_pkg::GROUP_MASK;
  assign found       = (grp_bits != '0);
  assign exhausted   = (steps == LAST_GROUP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jcgp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    req_ready        = 1'b0;
    res_valid        = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = rnd;
    mod_req.divisor  = jcgp_pkg::popcount(grp_bits);
    unique case (state)
      jcgp_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = jcgp_pkg::ST_SCAN;
        end
      end
      jcgp_pkg::ST_SCAN: begin
        if (found) begin
          mod_req.start = 1'b1;
          state_next    = jcgp_pkg::ST_DIV;
        end else if (exhausted) begin
          state_next = jcgp_pkg::ST_OUT;
        end
      end
      jcgp_pkg::ST_DIV: begin
        if (mod_resp.done) begin
          state_next = jcgp_pkg::ST_OUT;
        end
      end
      jcgp_pkg::ST_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = jcgp_pkg::ST_IDLE;
        end
      end
      default: state_next = jcgp_pkg::ST_IDLE;
    endcase
  end

  assign req_fire = req_valid && req_ready;
  assign res_fire = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_pointer <= '0;
    end else if (state == jcgp_pkg::ST_DIV && mod_resp.done) begin
      group_pointer <= grp_after;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      mask  <= channel_mask;
      rnd   <= random_value;
      grp   <= start_group;
      steps <= '0;
    end else if (state == jcgp_pkg::ST_SCAN) begin
      if (found) begin
        bits <= grp_bits;
      end else if (exhausted) begin
        channel_index <= '0;
        status        <= jcgp_pkg::STATUS_NONE;
        next_group    <= start_group;
      end else begin
        grp   <= grp_after;
        steps <= steps + 1'b1;
      end
    end else if (state == jcgp_pkg::ST_DIV && mod_resp.done) begin
      channel_index <= {grp, jcgp_pkg::nth_set(bits, mod_resp.rem)};
      status        <= jcgp_pkg::STATUS_OK;
      next_group    <= grp_after;
    end else if (res_fire) begin
      steps <= '0;
    end
  end

  jcgp_mod_unit u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mod_req),
    .resp (mod_resp)
  );

endmodule

>>> dv/testbench.sv
module testbench;
  import jcgp_pkg::*;

  localparam int NUM_GROUPS     = NUM_GROUPS_DEFAULT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;
  localparam int PHASE_REQUESTS = 400;

  typedef struct packed {
    logic [CHAN_W-1:0] channel_index;
    logic              status;
    logic [GRP_W-1:0]  next_group;
  } pick_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              req_valid    = 1'b0;
  logic [MASK_W-1:0] channel_mask = '0;
  logic [RAND_W-1:0] random_value = '0;
  logic              res_ready    = 1'b0;
  logic              req_ready;
  logic              res_valid;
  logic [CHAN_W-1:0] channel_index;
  logic              status;
  logic [GRP_W-1:0]  next_group;

  logic [GRP_W-1:0] group_ptr = '0;
  pick_t            picks_pending[$];
  int               mismatch_count = 0;
  int               quiet_cycles   = 0;
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;

  join_channel_group_picker #(
    .NUM_GROUPS(NUM_GROUPS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .channel_mask (channel_mask),
    .random_value (random_value),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .channel_index(channel_index),
    .status       (status),
    .next_group   (next_group)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // round-robin group scan from the pointer, then the (rnd mod count)-th free channel
  function automatic pick_t pick_channel(input logic [MASK_W-1:0] mask,
                                         input logic [RAND_W-1:0] rnd);
    pick_t                  r;
    int                     start;
    int                     g;
    int                     cnt;
    int                     sel;
    int                     seen;
    bit                     found;
    logic [GROUP_WIDTH-1:0] bits;
    start = (int'(group_ptr) < NUM_GROUPS) ? int'(group_ptr) : 0;
    r.channel_index = '0;
    r.status        = STATUS_NONE;
    r.next_group    = GRP_W'(start);
    found = 1'b0;
    g = start;
    for (int k = 0; k < NUM_GROUPS; k++) begin
      bits = mask[g*GROUP_WIDTH +: GROUP_WIDTH];
      cnt  = $countones(bits);
      if (!found && cnt != 0) begin
        found = 1'b1;
        sel   = int'(rnd) % cnt;
        seen  = 0;
        for (int i = 0; i < GROUP_WIDTH; i++) begin
          if (bits[i]) begin
            if (seen == sel) r.channel_index = CHAN_W'(g*GROUP_WIDTH + i);
            seen++;
          end
        end
        r.status     = STATUS_OK;
        r.next_group = GRP_W'((g + 1 >= NUM_GROUPS) ? 0 : g + 1);
      end
      g = (g + 1 >= NUM_GROUPS) ? 0 : g + 1;
    end
    return r;
  endfunction

  function automatic logic [MASK_W-1:0] random_channel_mask();
    logic [MASK_W-1:0] m;
    m = '0;
    case ($urandom_range(9))
      0: m = '0;
      1, 2: m = {$urandom, $urandom};
      3, 4: begin
        m[$urandom_range(NUM_GROUPS-1)*GROUP_WIDTH +: GROUP_WIDTH] =
            GROUP_WIDTH'($urandom_range(1, 255));
      end
      5: m[$urandom_range(MASK_W-1)] = 1'b1;
      6: m = '1;
      7, 8: begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
          if ($urandom_range(3) == 0) begin
            m[g*GROUP_WIDTH +: GROUP_WIDTH] = GROUP_WIDTH'($urandom_range(1, 255));
          end
        end
      end
      default: m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
    return m;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [MASK_W-1:0] mask, input logic [RAND_W-1:0] rnd);
    pick_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid    <= 1'b1;
    channel_mask <= mask;
    random_value <= rnd;
    do @(posedge clk); while (!req_ready);
    want      = pick_channel(mask, rnd);
    group_ptr = want.next_group;
    picks_pending.push_back(want);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (picks_pending.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int count, input int send_pct, input int recv_pct);
    wait_drained();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_request(random_channel_mask(), RAND_W'($urandom_range(255)));
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // empty mask from reset pointer
    send_request(64'h0, 8'd0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 8'd255);
    // scan runs on to the last group, and the pointer wraps to group 0
    send_request(64'h8000_0000_0000_0000, 8'd255);
    send_request(64'h0000_0000_0000_0001, 8'd0);
    // empty mask echoes a nonzero pointer
    send_request(64'h0, 8'd255);
    send_request(64'h0000_0000_0000_00FF, 8'd7);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 8'd3);
    send_request(64'h5555_5555_5555_5555, 8'd255);
    // group counts one through eight
    for (int i = 0; i < 8; i++) send_request(64'hFF7F_3F1F_0F07_0301, RAND_W'(200 + i));
    send_request(64'h0000_0000_8000_0000, 8'd6);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 8'd128);
  endtask

  task automatic test_no_idle();
    run_random_phase(PHASE_REQUESTS, 0, 0);
  endtask

  task automatic test_sender_idle();
    run_random_phase(PHASE_REQUESTS, 75, 0);
  endtask

  task automatic test_receiver_stall();
    run_random_phase(PHASE_REQUESTS, 0, 75);
  endtask

  task automatic test_both_idle();
    run_random_phase(PHASE_REQUESTS, 18, 18);
  endtask

  task automatic test_pause_until_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 50;
    repeat (30) begin
      wait_drained();
      send_request(random_channel_mask(), RAND_W'($urandom_range(255)));
    end
  endtask

  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_picks
    pick_t want;
    if (!rst && res_valid && res_ready) begin
      if (picks_pending.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = picks_pending.pop_front();
        if (channel_index !== want.channel_index)
          report_mismatch($sformatf("channel_index %0d, expected %0d",
                                    channel_index, want.channel_index));
        if (status !== want.status)
          report_mismatch($sformatf("status %0b, expected %0b", status, want.status));
        if (next_group !== want.next_group)
          report_mismatch($sformatf("next_group %0d, expected %0d",
                                    next_group, want.next_group));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_pause_until_drained();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && picks_pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/jcgp_pkg.sv
hw/rtl/jcgp_mod_unit.sv
hw/rtl/join_channel_group_picker.sv
dv/testbench.sv
